// File: rtl/palette_brightness_contrast_alpha_macros.svh
// Assertion macros used by the checker file of the palette correction block.
`ifndef PALETTE_BRIGHTNESS_CONTRAST_ALPHA_MACROS_SVH
`define PALETTE_BRIGHTNESS_CONTRAST_ALPHA_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PBCA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define PBCA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/pbca_pkg.sv
package pbca_pkg;

  // Field and bus widths
  localparam int unsigned ChanW     = 8;
  localparam int unsigned WordW     = 16;
  localparam int unsigned InDataW   = 5 * ChanW;
  localparam int unsigned OutDataW  = ChanW + 4 * WordW;
  localparam int unsigned CfgAddrW  = 2;

  // Register indexes
  localparam logic [CfgAddrW-1:0] RegContrast   = 2'd0;
  localparam logic [CfgAddrW-1:0] RegBrightness = 2'd1;
  localparam logic [CfgAddrW-1:0] RegAlphaLevel = 2'd2;

  // Register reset values
  localparam logic [ChanW-1:0] ContrastRst   = 8'd128;
  localparam logic [ChanW-1:0] BrightnessRst = 8'd128;
  localparam logic [ChanW-1:0] AlphaLevelRst = 8'd33;

  // Arithmetic constants
  localparam logic [ChanW-1:0] AlphaOpaque  = 8'd255;
  localparam logic [WordW-1:0] RedBlackWord = 16'h0100;
  localparam logic [9:0]       Recip3       = 10'd683;  // 2^11 / 3, rounded up

  // Signed product of (c - 128) and (contrast + 64)
  typedef logic signed [16:0] chan_prod_t;

  typedef struct packed {
    logic [ChanW-1:0] alpha;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] index;
  } in_item_t;

  typedef struct packed {
    logic [WordW-1:0] transp_word;
    logic [WordW-1:0] blue_word;
    logic [WordW-1:0] green_word;
    logic [WordW-1:0] red_word;
    logic [ChanW-1:0] entry_out;
  } out_item_t;

  // Scale a channel's distance from mid grey by the contrast gain
  function automatic chan_prod_t chan_prod(logic [ChanW-1:0] c, logic [ChanW-1:0] k);
    logic signed [8:0]  dc;
    logic signed [9:0]  gain;
    logic signed [18:0] prod;
    dc   = $signed({1'b0, c}) - 9'sd128;
    gain = $signed({2'b00, k}) + 10'sd64;
    prod = dc * gain;
    return $signed(prod[16:0]);
  endfunction

  // Divide by 192 toward zero, add brightness offset and clamp to 0..255
  function automatic logic [ChanW-1:0] chan_map(chan_prod_t p, logic [ChanW-1:0] bright);
    logic              neg;
    logic [16:0]       mag;
    logic [9:0]        by64;
    logic [19:0]       scaled;
    logic [7:0]        quot;
    logic signed [10:0] sq;
    logic signed [10:0] sum;
    neg    = p[16];
    mag    = neg ? 17'(-p) : 17'(p);
    by64   = mag[15:6];
    scaled = 20'(by64) * 20'(Recip3);
    quot   = scaled[18:11];
    sq     = neg ? -$signed({3'b000, quot}) : $signed({3'b000, quot});
    sum    = sq + $signed({3'b000, bright});
    if (sum < 11'sd0) begin
      return '0;
    end else if (sum > 11'sd255) begin
      return 8'hFF;
    end
    return sum[7:0];
  endfunction

  // Scale transparency by level/256, keeping the opaque value 255 unchanged
  function automatic logic [ChanW-1:0] alpha_map(logic [ChanW-1:0] a, logic [ChanW-1:0] lvl);
    logic [15:0] prod;
    prod = 16'(a) * 16'(lvl);
    return (a == AlphaOpaque) ? AlphaOpaque : prod[15:8];
  endfunction

endpackage

// File: rtl/palette_brightness_contrast_alpha.sv
// Accepted items are registered in stage one and then in the output register.
// Throughput: one item per cycle; the contrast multiply is registered before the
// divide-by-192 reciprocal multiply, and both stages stall only when the output is held.
// Reset (rst_ni low, asynchronous): all stages empty, contrast and brightness 128,
// alpha level 33.
module palette_brightness_contrast_alpha
  import pbca_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration writes
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [ChanW-1:0]    cfg_wdata_i,
  // Input palette entries
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // entry_index[7:0], red_in[15:8], green_in[23:16], blue_in[31:24], alpha_in[39:32]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // Colormap words
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // entry_out[7:0], red_word[23:8], green_word[39:24], blue_word[55:40],
  // transp_word[71:56]
  output logic [OutDataW-1:0] m_axis_tdata
);

  logic [ChanW-1:0] contrast_q, brightness_q, alpha_level_q;

  in_item_t   in_item;
  logic       rdy1, rdy2;
  logic       v1_q, v2_q;
  logic [ChanW-1:0] idx1_q, alpha1_q;
  chan_prod_t red1_q, green1_q, blue1_q;
  out_item_t  out_q, out_d;

  assign in_item = in_item_t'(s_axis_tdata);

  // Advance a stage when it is empty or its contents move on
  assign rdy2          = !v2_q || m_axis_tready;
  assign rdy1          = !v1_q || rdy2;
  assign s_axis_tready = rdy1;
  assign m_axis_tvalid = v2_q;
  assign m_axis_tdata  = out_q;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      contrast_q    <= ContrastRst;
      brightness_q  <= BrightnessRst;
      alpha_level_q <= AlphaLevelRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegContrast:   contrast_q    <= cfg_wdata_i;
        RegBrightness: brightness_q  <= cfg_wdata_i;
        RegAlphaLevel: alpha_level_q <= cfg_wdata_i;
        default:       ;
      endcase
    end
  end

  // Track occupancy of both stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= s_axis_tvalid;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
    end
  end

  // Stage one: contrast products and scaled transparency
  always_ff @(posedge clk_i) begin
    if (rdy1 && s_axis_tvalid) begin
      idx1_q   <= in_item.index;
      red1_q   <= chan_prod(in_item.red, contrast_q);
      green1_q <= chan_prod(in_item.green, contrast_q);
      blue1_q  <= chan_prod(in_item.blue, contrast_q);
      alpha1_q <= alpha_map(in_item.alpha, alpha_level_q);
    end
  end

  // Stage two: divide, offset, clamp and build the colormap words
  always_comb begin
    logic [ChanW-1:0] red_c;
    red_c             = chan_map(red1_q, brightness_q);
    out_d.entry_out   = idx1_q;
    out_d.red_word    = (red_c == '0) ? RedBlackWord : {red_c, 8'h00};
    out_d.green_word  = {chan_map(green1_q, brightness_q), 8'h00};
    out_d.blue_word   = {chan_map(blue1_q, brightness_q), 8'h00};
    out_d.transp_word = {alpha1_q, 8'h00};
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      out_q <= out_d;
    end
  end

endmodule

// File: rtl/pbca_checker.sv
`include "palette_brightness_contrast_alpha_macros.svh"

module pbca_checker
  import pbca_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  // Hold a stalled result item
  `PBCA_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result item changed")

  // Drop all items during reset
  `PBCA_ASSERT_ALWAYS(a_rst_empty, !rst_ni |=> !m_axis_tvalid, "result valid during reset")

  // Red word never zero
  `PBCA_ASSERT(a_red_nonzero, m_axis_tvalid |-> m_axis_tdata[23:8] != 16'h0000, "red word is zero")

  // Words carry their value in the upper byte only
  `PBCA_ASSERT(a_low_bytes, m_axis_tvalid |-> (m_axis_tdata[15:8] == 8'h00 || m_axis_tdata[23:8] == RedBlackWord) && m_axis_tdata[31:24] == 8'h00 && m_axis_tdata[47:40] == 8'h00 && m_axis_tdata[63:56] == 8'h00, "low byte of a word set")

  // Accept input whenever the output side is free
  `PBCA_ASSERT(a_ready_free, !m_axis_tvalid |-> s_axis_tready, "input blocked while output empty")

endmodule

bind palette_brightness_contrast_alpha pbca_checker u_pbca_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
